### sv/trq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trq_pkg: shared types and constants of the task ready queue scheduler
// command and response words, mode and slot state codes, controller handshake
// ----------------------------------------------------------------------------
package trq_pkg;

	localparam int TASK_COUNT = 16;
	localparam int IDW = (TASK_COUNT > 2) ? $clog2(TASK_COUNT) : 1;
	localparam int CW  = $clog2(TASK_COUNT + 1);

	localparam logic [2:0] MODE_CREATE  = 3'd0;
	localparam logic [2:0] MODE_YIELD   = 3'd1;
	localparam logic [2:0] MODE_SUSPEND = 3'd2;
	localparam logic [2:0] MODE_WAKE    = 3'd3;
	localparam logic [2:0] MODE_TICK    = 3'd4;
	localparam logic [2:0] MODE_RUN     = 3'd5;
	localparam logic [2:0] MODE_DELETE  = 3'd6;

	localparam logic [1:0] ST_READY     = 2'd0;
	localparam logic [1:0] ST_RUNNING   = 2'd1;
	localparam logic [1:0] ST_SUSPENDED = 2'd2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [4:0]  task_id;
		logic [31:0] delay_ticks;
	} cmd_t;

	typedef struct packed {
		logic [4:0] running_task;
		logic [5:0] created_task;
		logic       accepted;
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic start;
		logic step;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
	} dp_sts_t;

endpackage

### sv/trq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trq_datapath: slot table, index fifos and command registers
// executes one micro step per cycle as ordered by the controller
// ----------------------------------------------------------------------------
module trq_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  trq_pkg::dp_cmd_t  ctl,
	input  trq_pkg::cmd_t     cmd,
	output trq_pkg::dp_sts_t  sts,
	output trq_pkg::rsp_t     rsp
);

	localparam int TC  = trq_pkg::TASK_COUNT;
	localparam int IDW = trq_pkg::IDW;
	localparam int CW  = trq_pkg::CW;

	function automatic logic [IDW-1:0] nxt(input logic [IDW-1:0] i);
		nxt = (i == IDW'(TC - 1)) ? '0 : i + 1'b1;
	endfunction

	logic [2:0]     mode_q;
	logic [4:0]     id_q;
	logic [31:0]    delay_q;
	logic [IDW-1:0] cur_q;
	logic [5:0]     created_q;
	logic           ok_q;
	logic           found_q;
	logic           tgt_ready_q;
	logic [CW-1:0]  left_q;
	trq_pkg::rsp_t  rsp_q;

	logic           valid_q [TC];
	logic [1:0]     state_q [TC];
	logic [31:0]    dly_q   [TC];

	logic [IDW-1:0] fbuf_q [TC];
	logic [IDW-1:0] rbuf_q [TC];
	logic [IDW-1:0] sbuf_q [TC];
	logic [IDW-1:0] fhead_q, ftail_q, rhead_q, rtail_q, shead_q, stail_q;
	logic [CW-1:0]  fcnt_q, rcnt_q, scnt_q;

	logic           f_push, f_pop, r_push, r_pop, s_push, s_pop;
	logic [IDW-1:0] f_val, r_val, s_val;
	logic           f_wr, r_wr, s_wr;

	logic [IDW-1:0] hf, hr, hs, xh, id_ix;
	logic           id_ok, wake_ok, run_ok, hit;

	assign hf      = fbuf_q[fhead_q];
	assign hr      = rbuf_q[rhead_q];
	assign hs      = sbuf_q[shead_q];
	assign xh      = tgt_ready_q ? hr : hs;
	assign id_ix   = id_q[IDW-1:0];
	assign id_ok   = {1'b0, id_q} < 6'(TC);
	assign wake_ok = id_ok && valid_q[id_ix] && (state_q[id_ix] == trq_pkg::ST_SUSPENDED);
	assign run_ok  = id_ok && valid_q[id_ix] && (state_q[id_ix] != trq_pkg::ST_RUNNING);
	assign hit     = ({{(5-IDW){1'b0}}, xh} == id_q);
	assign sts.busy = (left_q != '0) && !found_q;
	assign rsp     = rsp_q;

	// fifo traffic of this cycle
	always_comb begin
		f_push = 1'b0; f_pop = 1'b0; f_val = cur_q;
		r_push = 1'b0; r_pop = 1'b0; r_val = cur_q;
		s_push = 1'b0; s_pop = 1'b0; s_val = cur_q;
		if (ctl.start) begin
			case (mode_q)
				trq_pkg::MODE_CREATE: if (fcnt_q != '0) begin
					f_pop = 1'b1; r_push = 1'b1; r_val = hf;
				end
				trq_pkg::MODE_YIELD: if (rcnt_q != '0) begin
					r_push = 1'b1; r_pop = 1'b1;
				end
				trq_pkg::MODE_SUSPEND: if (rcnt_q != '0) begin
					s_push = 1'b1; r_pop = 1'b1;
				end
				trq_pkg::MODE_DELETE: if (rcnt_q != '0) begin
					f_push = 1'b1; r_pop = 1'b1;
				end
				trq_pkg::MODE_RUN: if (run_ok) begin
					r_push = 1'b1;
				end
				default: ;
			endcase
		end else if (ctl.step) begin
			if (mode_q == trq_pkg::MODE_TICK) begin
				s_pop = 1'b1;
				if (dly_q[xh] == 32'd1) begin
					r_push = 1'b1; r_val = xh;
				end else begin
					s_push = 1'b1; s_val = xh;
				end
			end else begin
				if (tgt_ready_q) r_pop = 1'b1;
				else s_pop = 1'b1;
				if (hit) begin
					if (mode_q == trq_pkg::MODE_WAKE) begin
						r_push = 1'b1; r_val = id_ix;
					end
				end else if (tgt_ready_q) begin
					r_push = 1'b1; r_val = xh;
				end else begin
					s_push = 1'b1; s_val = xh;
				end
			end
		end
	end

	// a push lands only if the fifo has room after this cycle's pop
	assign f_wr = f_push && ((fcnt_q - CW'(f_pop)) < CW'(TC));
	assign r_wr = r_push && ((rcnt_q - CW'(r_pop)) < CW'(TC));
	assign s_wr = s_push && ((scnt_q - CW'(s_pop)) < CW'(TC));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fhead_q <= '0; fcnt_q <= CW'(TC - 1);
			rhead_q <= '0; rtail_q <= '0; rcnt_q <= '0;
			shead_q <= '0; stail_q <= '0; scnt_q <= '0;
			for (int i = 0; i < TC; i++) begin
				fbuf_q[i] <= (i < TC - 1) ? IDW'(i + 1) : '0;
			end
			ftail_q <= IDW'(TC - 1);
		end else begin
			if (f_pop) fhead_q <= nxt(fhead_q);
			if (f_wr) begin
				fbuf_q[ftail_q] <= f_val;
				ftail_q <= nxt(ftail_q);
			end
			fcnt_q <= fcnt_q + CW'(f_wr) - CW'(f_pop);
			if (r_pop) rhead_q <= nxt(rhead_q);
			if (r_wr) begin
				rbuf_q[rtail_q] <= r_val;
				rtail_q <= nxt(rtail_q);
			end
			rcnt_q <= rcnt_q + CW'(r_wr) - CW'(r_pop);
			if (s_pop) shead_q <= nxt(shead_q);
			if (s_wr) begin
				sbuf_q[stail_q] <= s_val;
				stail_q <= nxt(stail_q);
			end
			scnt_q <= scnt_q + CW'(s_wr) - CW'(s_pop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			left_q <= '0;
			found_q <= 1'b0;
			created_q <= 6'(TC);
			ok_q <= 1'b0;
			tgt_ready_q <= 1'b0;
			for (int i = 0; i < TC; i++) begin
				valid_q[i] <= (i == 0);
				state_q[i] <= (i == 0) ? trq_pkg::ST_RUNNING : trq_pkg::ST_READY;
				dly_q[i]   <= '0;
			end
		end else begin
			if (ctl.start) begin
				created_q <= 6'(TC);
				ok_q      <= 1'b0;
				found_q   <= 1'b0;
				left_q    <= '0;
				case (mode_q)
					trq_pkg::MODE_CREATE: if (fcnt_q != '0) begin
						valid_q[hf] <= 1'b1;
						state_q[hf] <= trq_pkg::ST_READY;
						dly_q[hf]   <= '0;
						created_q   <= 6'(hf);
						ok_q        <= 1'b1;
					end
					trq_pkg::MODE_YIELD: begin
						ok_q <= 1'b1;
						if (rcnt_q != '0) begin
							state_q[cur_q] <= trq_pkg::ST_READY;
							state_q[hr]    <= trq_pkg::ST_RUNNING;
							cur_q          <= hr;
						end
					end
					trq_pkg::MODE_SUSPEND: if (rcnt_q != '0) begin
						state_q[cur_q] <= trq_pkg::ST_SUSPENDED;
						dly_q[cur_q]   <= delay_q;
						state_q[hr]    <= trq_pkg::ST_RUNNING;
						cur_q          <= hr;
						ok_q           <= 1'b1;
					end
					trq_pkg::MODE_DELETE: if (rcnt_q != '0) begin
						valid_q[cur_q] <= 1'b0;
						state_q[hr]    <= trq_pkg::ST_RUNNING;
						cur_q          <= hr;
						ok_q           <= 1'b1;
					end
					trq_pkg::MODE_WAKE: if (wake_ok) begin
						left_q      <= scnt_q;
						tgt_ready_q <= 1'b0;
					end
					trq_pkg::MODE_TICK: begin
						left_q      <= scnt_q;
						tgt_ready_q <= 1'b0;
						ok_q        <= 1'b1;
					end
					trq_pkg::MODE_RUN: if (run_ok) begin
						state_q[cur_q] <= trq_pkg::ST_READY;
						ok_q           <= 1'b1;
						if (state_q[id_ix] == trq_pkg::ST_READY) begin
							tgt_ready_q <= 1'b1;
							left_q      <= rcnt_q + CW'(rcnt_q < CW'(TC));
						end else begin
							tgt_ready_q <= 1'b0;
							left_q      <= scnt_q;
						end
					end
					default: ;
				endcase
			end else if (ctl.step) begin
				left_q <= left_q - 1'b1;
				if (mode_q == trq_pkg::MODE_TICK) begin
					if (dly_q[xh] != '0) dly_q[xh] <= dly_q[xh] - 1'b1;
					if (dly_q[xh] == 32'd1) state_q[xh] <= trq_pkg::ST_READY;
				end else if (hit) begin
					found_q <= 1'b1;
					if (mode_q == trq_pkg::MODE_WAKE) begin
						state_q[id_ix] <= trq_pkg::ST_READY;
						ok_q           <= 1'b1;
					end else begin
						state_q[id_ix] <= trq_pkg::ST_RUNNING;
						cur_q          <= id_ix;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			mode_q  <= cmd.mode;
			id_q    <= cmd.task_id;
			delay_q <= cmd.delay_ticks;
		end
		if (ctl.load) begin
			rsp_q.running_task <= 5'(cur_q);
			rsp_q.created_task <= created_q;
			rsp_q.accepted     <= ok_q;
		end
	end

endmodule

### sv/trq_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trq_controller: command sequencer
// accept, start, walk a fifo one entry per cycle, then hand off the response
// ----------------------------------------------------------------------------
module trq_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  trq_pkg::dp_sts_t  sts,
	output trq_pkg::dp_cmd_t  ctl
);

	typedef enum logic [1:0] {S_IDLE, S_START, S_LOOP, S_FINISH} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   room;

	assign room      = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	assign ctl.latch = (state_q == S_IDLE) && cmd_valid;
	assign ctl.start = (state_q == S_START);
	assign ctl.step  = (state_q == S_LOOP) && sts.busy;
	assign ctl.load  = (state_q == S_FINISH) && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new word is loaded, or the pending one holds while stalled
			rsp_valid_q <= ((state_q == S_FINISH) && room) || (rsp_valid_q && rsp_stall);
			unique case (state_q)
				S_IDLE:   if (cmd_valid) state_q <= S_START;
				S_START:  state_q <= S_LOOP;
				S_LOOP:   if (!sts.busy) state_q <= S_FINISH;
				S_FINISH: if (room) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### sv/task_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_ready_queue_scheduler: round robin task scheduler with tick delays
// slot table plus free, ready and suspended index fifos, one response per command
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               word
//  cmd      in         cmd_valid / cmd_stall   trq_pkg::cmd_t (mode, task_id, delay_ticks)
//  rsp      out        rsp_valid / rsp_stall   trq_pkg::rsp_t (running_task, created_task,
//                                              accepted)
//
//  one command at a time: accept, a start step, then a walk over fifo entries
//  (tick, wake, run; up to TASK_COUNT entries), then the response load; create,
//  yield, suspend, delete and refused commands walk no fifo entries
//  reset: task 0 running, slots 1 .. TASK_COUNT-1 in the free fifo
//  a stalled response holds in its register; the next command is taken meanwhile
//  and waits at the finish step until the response register frees
//
module task_ready_queue_scheduler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  trq_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output trq_pkg::rsp_t  rsp
);

	// control and status between sequencer and datapath
	trq_pkg::dp_cmd_t ctl;
	trq_pkg::dp_sts_t sts;

	trq_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	trq_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

	// a taken command closes the input until its response is loaded
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("command accepted while previous one in flight");

	// a slot handed out by create always comes with accepted set
	a_create_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.created_task != 6'(trq_pkg::TASK_COUNT))) |-> rsp.accepted)
		else $error("created slot reported without accept");

	// the running task is always a real slot
	a_running_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ({1'b0, rsp.running_task} < 6'(trq_pkg::TASK_COUNT)))
		else $error("running task out of range");

endmodule

### dv/tb_task_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_task_ready_queue_scheduler: self-checking bench of the task scheduler
// a scheduler model in the bench predicts every response word; named test
// tasks drive directed and random command words under random idling
// ----------------------------------------------------------------------------
module tb_task_ready_queue_scheduler;

	localparam int NT = trq_pkg::TASK_COUNT;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	trq_pkg::cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	trq_pkg::rsp_t rsp;

	task_ready_queue_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// model of the slot table and the three index fifos
	logic        sv_valid [NT];
	logic [1:0]  sv_state [NT];
	logic [31:0] sv_delay [NT];
	int          q_free [$];
	int          q_ready [$];
	int          q_susp [$];
	int          cur_task;

	trq_pkg::rsp_t rsp_expected [$];
	int   mismatches;
	bit   timed_out;
	int   idle_cycles;
	bit   hold_rsp;   // long receiver hold-off

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic sched_reset();
		for (int i = 0; i < NT; i++) begin
			sv_valid[i] = 1'b0;
			sv_state[i] = trq_pkg::ST_READY;
			sv_delay[i] = '0;
		end
		q_free = {};
		q_ready = {};
		q_susp = {};
		for (int i = 1; i < NT; i++) q_free.push_back(i);
		cur_task = 0;
		sv_valid[0] = 1'b1;
		sv_state[0] = trq_pkg::ST_RUNNING;
	endtask

	// remove id from a fifo, entries ahead of it rotate to the tail
	function automatic bit pull_id(ref int q[$], input int id);
		int n;
		int v;
		n = q.size();
		for (int i = 0; i < n; i++) begin
			v = q.pop_front();
			if (v == id) return 1'b1;
			q.push_back(v);
		end
		return 1'b0;
	endfunction

	function automatic void take_ready_head();
		if (q_ready.size() > 0) begin
			cur_task = q_ready.pop_front();
			sv_state[cur_task] = trq_pkg::ST_RUNNING;
		end
	endfunction

	function automatic trq_pkg::rsp_t schedule(trq_pkg::cmd_t c);
		trq_pkg::rsp_t r;
		int created;
		bit ok;
		int id;
		int n;
		int v;
		bit hit;
		created = NT;
		ok = 1'b0;
		id = int'(c.task_id);
		case (c.mode)
			trq_pkg::MODE_CREATE: begin
				if (q_free.size() > 0) begin
					v = q_free.pop_front();
					sv_valid[v] = 1'b1;
					sv_state[v] = trq_pkg::ST_READY;
					sv_delay[v] = '0;
					q_ready.push_back(v);
					created = v;
					ok = 1'b1;
				end
			end
			trq_pkg::MODE_YIELD: begin
				q_ready.push_back(cur_task);
				sv_state[cur_task] = trq_pkg::ST_READY;
				take_ready_head();
				ok = 1'b1;
			end
			trq_pkg::MODE_SUSPEND: begin
				if (q_ready.size() > 0) begin
					q_susp.push_back(cur_task);
					sv_state[cur_task] = trq_pkg::ST_SUSPENDED;
					sv_delay[cur_task] = c.delay_ticks;
					take_ready_head();
					ok = 1'b1;
				end
			end
			trq_pkg::MODE_WAKE: begin
				if (id < NT && sv_valid[id] && sv_state[id] == trq_pkg::ST_SUSPENDED) begin
					if (pull_id(q_susp, id)) begin
						q_ready.push_back(id);
						sv_state[id] = trq_pkg::ST_READY;
						ok = 1'b1;
					end
				end
			end
			trq_pkg::MODE_TICK: begin
				n = q_susp.size();
				for (int i = 0; i < n; i++) begin
					v = q_susp.pop_front();
					if (sv_delay[v] != 0) begin
						sv_delay[v] = sv_delay[v] - 32'd1;
						if (sv_delay[v] == 0) begin
							q_ready.push_back(v);
							sv_state[v] = trq_pkg::ST_READY;
							continue;
						end
					end
					q_susp.push_back(v);
				end
				ok = 1'b1;
			end
			trq_pkg::MODE_RUN: begin
				if (id < NT && sv_valid[id] && sv_state[id] != trq_pkg::ST_RUNNING) begin
					bit from_ready;
					from_ready = (sv_state[id] == trq_pkg::ST_READY);
					q_ready.push_back(cur_task);
					sv_state[cur_task] = trq_pkg::ST_READY;
					if (from_ready) hit = pull_id(q_ready, id);
					else hit = pull_id(q_susp, id);
					if (hit) begin
						cur_task = id;
						sv_state[id] = trq_pkg::ST_RUNNING;
					end
					ok = 1'b1;
				end
			end
			trq_pkg::MODE_DELETE: begin
				if (q_ready.size() > 0) begin
					q_free.push_back(cur_task);
					sv_valid[cur_task] = 1'b0;
					take_ready_head();
					ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.running_task = cur_task[4:0];
		r.created_task = created[5:0];
		r.accepted = ok;
		return r;
	endfunction

	// send one command word after a random gap, predict at acceptance
	task automatic send_cmd(logic [2:0] m, logic [4:0] id, logic [31:0] d, bit no_gap = 0);
		int gap;
		trq_pkg::cmd_t c;
		gap = no_gap ? 0 : $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) @(posedge clk);
		c.mode = m;
		c.task_id = id;
		c.delay_ticks = d;
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		rsp_expected.push_back(schedule(c));
		cmd_valid <= 1'b0;
		// the block sits in its start step here and cannot take a word
		@(posedge clk);
	endtask

	task automatic drain();
		while (rsp_expected.size() > 0 && !timed_out) @(posedge clk);
		repeat (NT + 8) @(posedge clk);
	endtask

	// receiver: random stall per word, long hold when asked
	initial begin
		int w;
		rsp_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 10);
			if ($urandom_range(0, 3) == 0) w = 0;
			if (w > 0 || hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (w) @(posedge clk);
				while (hold_rsp) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response word %p", rsp);
			end else begin
				trq_pkg::rsp_t e;
				e = rsp_expected.pop_front();
				if (e !== rsp) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, rsp);
				end
			end
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("status: fail");
			$finish;
		end
	end

	task automatic rand_cmd();
		logic [2:0] m;
		logic [4:0] id;
		logic [31:0] d;
		m = 3'($urandom_range(0, 7));
		// mostly valid ids, sometimes out of range
		id = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, NT - 1));
		case ($urandom_range(0, 5))
			0: d = 32'd0;
			1: d = $urandom;
			2: d = 32'hffff_ffff;
			default: d = $urandom_range(1, 4);
		endcase
		send_cmd(m, id, d);
	endtask

	task automatic test_directed();
		send_cmd(trq_pkg::MODE_YIELD, 5'd0, 32'd0);   // yield with empty ready fifo
		send_cmd(trq_pkg::MODE_SUSPEND, 5'd0, 32'd5); // refused, nothing ready
		send_cmd(trq_pkg::MODE_DELETE, 5'd0, 32'd0);  // refused, nothing ready
		// last one finds no free slot
		for (int i = 0; i < NT; i++) send_cmd(trq_pkg::MODE_CREATE, 5'd0, 32'd0);
		send_cmd(trq_pkg::MODE_SUSPEND, 5'd0, 32'hffff_ffff);
		send_cmd(trq_pkg::MODE_SUSPEND, 5'd0, 32'd0); // wait until woken
		send_cmd(trq_pkg::MODE_SUSPEND, 5'd0, 32'd1);
		send_cmd(trq_pkg::MODE_TICK, 5'd0, 32'd0);
		send_cmd(trq_pkg::MODE_WAKE, 5'd1, 32'd0);
		send_cmd(trq_pkg::MODE_WAKE, 5'd31, 32'd0);   // out of range
		send_cmd(trq_pkg::MODE_WAKE, 5'd5, 32'd0);    // not suspended
		send_cmd(trq_pkg::MODE_RUN, 5'd0, 32'd0);     // suspended target keeps delay
		send_cmd(trq_pkg::MODE_RUN, 5'd20, 32'd0);
		send_cmd(trq_pkg::MODE_RUN, 5'd7, 32'd0);
		send_cmd(trq_pkg::MODE_DELETE, 5'd0, 32'd0);
		send_cmd(trq_pkg::MODE_RUN, 5'd7, 32'd0);     // invalid slot
		send_cmd(3'd7, 5'd31, 32'hffff_ffff);
		drain();
	endtask

	task automatic test_random();
		for (int i = 0; i < 1600; i++) rand_cmd();
		drain();
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_backpressure();
		hold_rsp = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_rsp = 1'b0;
			end
			for (int i = 0; i < 60; i++) send_cmd(3'($urandom_range(0, 6)),
				5'($urandom_range(0, NT - 1)), 32'($urandom_range(0, 3)), 1);
		join
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		hold_rsp = 1'b0;
		mismatches = 0;
		timed_out = 1'b0;
		idle_cycles = 0;
		sched_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		drain();
		if (mismatches == 0 && rsp_expected.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
